FILE: hw/rtl/rfid_pkg.sv
// ----------------------------------------------------------------------------
// RF interference detector package
// Beat types, detector state, configuration set and the operation, command
// and flag codes shared by the detector modules.
// ----------------------------------------------------------------------------
package rfid_pkg;

    localparam logic [9:0] COUNT_LIMIT = 10'd600;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_TIME = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_BREAK = 2'd3;

    localparam logic [3:0] FL_IDLE  = 4'b0000;
    localparam logic [3:0] FL_INT   = 4'b0001;
    localparam logic [3:0] FL_FRM   = 4'b0010;
    localparam logic [3:0] FL_TIME  = 4'b0100;
    localparam logic [3:0] FL_PAUSE = 4'b1000;

    localparam logic [1:0] CFG_FIXED_OFFSET    = 2'd0;
    localparam logic [1:0] CFG_OVERLAP_MARGIN  = 2'd1;
    localparam logic [1:0] CFG_FRAME_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_DEFAULT_OFFSET  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] base_level;
        logic [7:0]  appl_state;
        logic [15:0] max_frames;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  alarm_cmd;
        logic [15:0] alarm_value;
        logic [7:0]  offset_low;
        logic        frame_interferer;
        logic        time_interferer;
    } t_out_item;

    typedef struct packed {
        logic        dynamic_mode;
        logic [3:0]  detect_flags;
        logic [15:0] noise_offset;
        logic [9:0]  qualify_count;
    } t_state;

    typedef struct packed {
        logic [15:0] fixed_offset;
        logic [15:0] overlap_margin;
        logic [15:0] frame_threshold;
        logic [7:0]  default_offset;
    } t_cfg;

endpackage

FILE: hw/rtl/rfid_step.sv
// ----------------------------------------------------------------------------
// RF interference detector step logic
// Computes the next detector state and the result beat for one operation.
// ----------------------------------------------------------------------------
module rfid_step (
    input  rfid_pkg::t_in_item  i_item,
    input  rfid_pkg::t_state    i_state,
    input  rfid_pkg::t_cfg      i_cfg,
    output rfid_pkg::t_state    o_state,
    output rfid_pkg::t_out_item o_item
);

    logic [15:0] adapt_offset;
    logic [16:0] threshold;
    logic        above;
    logic        appl_active;
    logic        frames_ok;
    logic [10:0] count_inc;
    logic [1:0]  cmd;
    logic [15:0] value;
    rfid_pkg::t_state nxt;

    always_comb begin
        adapt_offset = i_state.noise_offset;
        if ((i_item.base_level != 16'd0) && i_state.dynamic_mode &&
            (i_item.base_level < i_state.noise_offset)) begin
            adapt_offset = {1'b0, i_state.noise_offset[15:1]} +
                           {1'b0, i_item.base_level[15:1]};
        end
        threshold   = {1'b0, adapt_offset} + {1'b0, i_cfg.overlap_margin};
        above       = {1'b0, i_item.base_level} > threshold;
        appl_active = i_item.appl_state != 8'd0;
        frames_ok   = i_item.max_frames >= i_cfg.frame_threshold;
        count_inc   = {1'b0, i_state.qualify_count} + 11'd1;
    end

    always_comb begin
        nxt   = i_state;
        cmd   = rfid_pkg::CMD_NONE;
        value = 16'd0;
        unique case (i_item.op)
            rfid_pkg::OP_TICK: begin
                nxt.noise_offset = adapt_offset;
                unique case (i_state.detect_flags)
                    rfid_pkg::FL_IDLE: begin
                        if (above) begin
                            if (appl_active) begin
                                if (count_inc > {1'b0, rfid_pkg::COUNT_LIMIT}) begin
                                    nxt.detect_flags  = rfid_pkg::FL_INT;
                                    nxt.qualify_count = rfid_pkg::COUNT_LIMIT;
                                end else begin
                                    nxt.qualify_count = count_inc[9:0];
                                end
                            end
                        end else begin
                            nxt.qualify_count = 10'd0;
                        end
                        cmd = rfid_pkg::CMD_STOP;
                    end
                    rfid_pkg::FL_INT: begin
                        if (above) begin
                            if (frames_ok) begin
                                nxt.qualify_count = 10'd0;
                                nxt.detect_flags  = rfid_pkg::FL_INT | rfid_pkg::FL_FRM;
                                cmd               = rfid_pkg::CMD_START;
                                value             = i_item.max_frames;
                            end else begin
                                nxt.qualify_count = rfid_pkg::COUNT_LIMIT;
                            end
                        end else if (i_state.qualify_count == 10'd0) begin
                            nxt.detect_flags = rfid_pkg::FL_IDLE;
                        end else begin
                            nxt.qualify_count = i_state.qualify_count - 10'd1;
                        end
                    end
                    rfid_pkg::FL_INT | rfid_pkg::FL_FRM: begin
                        if (!frames_ok) begin
                            nxt.detect_flags = rfid_pkg::FL_IDLE;
                        end else if (!appl_active) begin
                            nxt.detect_flags = i_state.detect_flags | rfid_pkg::FL_PAUSE;
                            cmd              = rfid_pkg::CMD_BREAK;
                        end
                    end
                    rfid_pkg::FL_INT | rfid_pkg::FL_FRM | rfid_pkg::FL_TIME: begin
                        if (!frames_ok) begin
                            nxt.detect_flags = rfid_pkg::FL_IDLE;
                            cmd              = rfid_pkg::CMD_STOP;
                        end
                    end
                    rfid_pkg::FL_INT | rfid_pkg::FL_FRM | rfid_pkg::FL_PAUSE: begin
                        if (appl_active) begin
                            nxt.detect_flags = rfid_pkg::FL_INT | rfid_pkg::FL_FRM;
                            cmd              = rfid_pkg::CMD_START;
                        end
                    end
                    default: begin
                        nxt.detect_flags = rfid_pkg::FL_IDLE;
                    end
                endcase
            end
            rfid_pkg::OP_TIME: begin
                nxt.detect_flags = i_state.detect_flags | rfid_pkg::FL_TIME;
            end
            rfid_pkg::OP_INIT: begin
                nxt.detect_flags  = rfid_pkg::FL_IDLE;
                nxt.qualify_count = 10'd0;
                if (i_cfg.fixed_offset != 16'd0) begin
                    nxt.dynamic_mode = 1'b0;
                    nxt.noise_offset = i_cfg.fixed_offset;
                end else begin
                    nxt.dynamic_mode = 1'b1;
                    nxt.noise_offset = {8'd0, i_cfg.default_offset};
                end
                cmd = rfid_pkg::CMD_STOP;
            end
            rfid_pkg::OP_NONE: begin
                cmd = rfid_pkg::CMD_NONE;
            end
        endcase
    end

    assign o_state                 = nxt;
    assign o_item.alarm_cmd        = cmd;
    assign o_item.alarm_value      = value;
    assign o_item.offset_low       = nxt.noise_offset[7:0];
    assign o_item.frame_interferer = |(nxt.detect_flags & rfid_pkg::FL_FRM);
    assign o_item.time_interferer  = |(nxt.detect_flags & rfid_pkg::FL_TIME);

endmodule

FILE: hw/rtl/rf_interference_detector.sv
// ----------------------------------------------------------------------------
// RF interference detector
// Tracks a noise offset and steps four interference flags per operation beat,
// answering each input beat with exactly one alarm result beat.
// ----------------------------------------------------------------------------
// Each input beat passes the input register, then the result register that
// holds the step result.
// Throughput: one beat per cycle while the result channel is not stalled.
// Reset: synchronous active-low reset clears configuration, detector state
// and both valid flags; the block is ready in the first cycle after reset.
module rf_interference_detector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rfid_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rfid_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    logic                r_in_valid;
    rfid_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    rfid_pkg::t_out_item r_out_data;
    rfid_pkg::t_state    r_state;
    rfid_pkg::t_cfg      r_cfg;
    rfid_pkg::t_state    n_state;
    rfid_pkg::t_out_item n_out_data;
    logic                advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    rfid_step u_step (
        .i_item  (r_in_data),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_item  (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_cfg       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rfid_pkg::CFG_FIXED_OFFSET:    r_cfg.fixed_offset    <= i_cfg_data;
                    rfid_pkg::CFG_OVERLAP_MARGIN:  r_cfg.overlap_margin  <= i_cfg_data;
                    rfid_pkg::CFG_FRAME_THRESHOLD: r_cfg.frame_threshold <= i_cfg_data;
                    rfid_pkg::CFG_DEFAULT_OFFSET:  r_cfg.default_offset  <= i_cfg_data[7:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: hw/rtl/rfid_checker.sv
// ----------------------------------------------------------------------------
// RF interference detector checker
// Port-level properties of the detector, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rfid_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rfid_pkg::t_out_item o_out_data
);

    // A result beat that is not taken stays with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // Only a start command carries a value.
    a_value_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.alarm_cmd != rfid_pkg::CMD_START)
        |-> o_out_data.alarm_value == 16'd0)
        else $error("alarm value without start command");

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An accepted input beat, with no result pending, shows up as a result beat after the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> ##1 o_out_valid)
        else $error("accepted beat produced no result");

endmodule

bind rf_interference_detector rfid_checker u_rfid_checker (.*);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// RF interference detector testbench
// Feeds operation beats and register writes into the detector and predicts
// every alarm beat with a behavioral copy of the detector. Each result beat
// is compared field by field. Both channels idle and stall at random, and
// long qualification runs carry the flags through every state.
// ----------------------------------------------------------------------------
module tb;

    localparam int HOLD_AT     = 1100;
    localparam int HOLD_CYCLES = 300;
    localparam int WALK_LEN    = 80;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    rfid_pkg::t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    logic      in_ready;
    logic      out_valid;
    rfid_pkg::t_out_item out_data;
    logic      cfg_ready;

    rfid_pkg::t_in_item  pending_ops[$];
    rfid_pkg::t_out_item expected_alarms[$];
    rfid_pkg::t_out_item want_alarm;

    rfid_pkg::t_state    det_state = '0;
    rfid_pkg::t_cfg      det_cfg   = '0;

    bit        quiet       = 1'b0;
    bit        hold_done   = 1'b0;
    int        send_gap    = 0;
    int        stall_left  = 0;
    int        hold_left   = 0;
    int        alarms_seen = 0;
    int        mismatches  = 0;

    rf_interference_detector u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic rfid_pkg::t_out_item detector_step(input rfid_pkg::t_in_item it);
        rfid_pkg::t_out_item r;
        logic      above;
        r = '0;
        r.alarm_cmd = rfid_pkg::CMD_NONE;
        case (it.op)
            rfid_pkg::OP_TICK: begin
                if (it.base_level != 16'd0 && det_state.dynamic_mode &&
                    it.base_level < det_state.noise_offset) begin
                    det_state.noise_offset = (det_state.noise_offset >> 1) +
                                             (it.base_level >> 1);
                end
                above = {1'b0, it.base_level} >
                        ({1'b0, det_state.noise_offset} + {1'b0, det_cfg.overlap_margin});
                case (det_state.detect_flags)
                    rfid_pkg::FL_IDLE: begin
                        if (above) begin
                            if (it.appl_state != 8'd0) begin
                                if (det_state.qualify_count >= rfid_pkg::COUNT_LIMIT) begin
                                    det_state.detect_flags =
                                        det_state.detect_flags | rfid_pkg::FL_INT;
                                    det_state.qualify_count = rfid_pkg::COUNT_LIMIT;
                                end else begin
                                    det_state.qualify_count = det_state.qualify_count + 10'd1;
                                end
                            end
                        end else begin
                            det_state.qualify_count = '0;
                        end
                        r.alarm_cmd = rfid_pkg::CMD_STOP;
                    end
                    rfid_pkg::FL_INT: begin
                        if (above) begin
                            det_state.qualify_count = rfid_pkg::COUNT_LIMIT;
                            if (it.max_frames >= det_cfg.frame_threshold) begin
                                det_state.qualify_count = '0;
                                det_state.detect_flags =
                                    det_state.detect_flags | rfid_pkg::FL_FRM;
                                r.alarm_cmd = rfid_pkg::CMD_START;
                                r.alarm_value = it.max_frames;
                            end
                        end else if (det_state.qualify_count == 10'd0) begin
                            det_state.detect_flags = det_state.detect_flags & ~rfid_pkg::FL_INT;
                        end else begin
                            det_state.qualify_count = det_state.qualify_count - 10'd1;
                        end
                    end
                    rfid_pkg::FL_INT | rfid_pkg::FL_FRM: begin
                        if (it.max_frames < det_cfg.frame_threshold) begin
                            det_state.detect_flags = rfid_pkg::FL_IDLE;
                        end else if (it.appl_state == 8'd0) begin
                            det_state.detect_flags = det_state.detect_flags | rfid_pkg::FL_PAUSE;
                            r.alarm_cmd = rfid_pkg::CMD_BREAK;
                        end
                    end
                    rfid_pkg::FL_INT | rfid_pkg::FL_FRM | rfid_pkg::FL_TIME: begin
                        if (it.max_frames < det_cfg.frame_threshold) begin
                            det_state.detect_flags = rfid_pkg::FL_IDLE;
                            r.alarm_cmd = rfid_pkg::CMD_STOP;
                        end
                    end
                    rfid_pkg::FL_INT | rfid_pkg::FL_FRM | rfid_pkg::FL_PAUSE: begin
                        if (it.appl_state != 8'd0) begin
                            det_state.detect_flags =
                                det_state.detect_flags & ~rfid_pkg::FL_PAUSE;
                            r.alarm_cmd = rfid_pkg::CMD_START;
                            r.alarm_value = '0;
                        end
                    end
                    default: det_state.detect_flags = rfid_pkg::FL_IDLE;
                endcase
            end
            rfid_pkg::OP_TIME: det_state.detect_flags = det_state.detect_flags | rfid_pkg::FL_TIME;
            rfid_pkg::OP_INIT: begin
                det_state.detect_flags = rfid_pkg::FL_IDLE;
                det_state.qualify_count = '0;
                if (det_cfg.fixed_offset != 16'd0) begin
                    det_state.dynamic_mode = 1'b0;
                    det_state.noise_offset = det_cfg.fixed_offset;
                end else begin
                    det_state.dynamic_mode = 1'b1;
                    det_state.noise_offset = {8'd0, det_cfg.default_offset};
                end
                r.alarm_cmd = rfid_pkg::CMD_STOP;
            end
            default: begin
            end
        endcase
        r.offset_low = det_state.noise_offset[7:0];
        r.frame_interferer = |(det_state.detect_flags & rfid_pkg::FL_FRM);
        r.time_interferer = |(det_state.detect_flags & rfid_pkg::FL_TIME);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s got 0x%0h expected 0x%0h",
                                      alarms_seen, name, got, want));
    endtask

    // Driver: holds a beat until it is taken, idles in bursts between beats.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_alarms.push_back(detector_step(in_data));
            if (!in_valid || in_ready) begin
                if (!quiet && send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 15) == 0) begin
                    send_gap = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    in_data <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch while beats keep coming.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && alarms_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: checks result beats and throttles the result channel.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                alarms_seen++;
                if (expected_alarms.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with no expected result",
                                              alarms_seen));
                end else begin
                    want_alarm = expected_alarms.pop_front();
                    check_field("alarm_cmd", 16'(out_data.alarm_cmd),
                                16'(want_alarm.alarm_cmd));
                    check_field("alarm_value", out_data.alarm_value, want_alarm.alarm_value);
                    check_field("offset_low", 16'(out_data.offset_low),
                                16'(want_alarm.offset_low));
                    check_field("frame_interferer", 16'(out_data.frame_interferer),
                                16'(want_alarm.frame_interferer));
                    check_field("time_interferer", 16'(out_data.time_interferer),
                                16'(want_alarm.time_interferer));
                end
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
            end else if (!quiet && stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] level_above(input logic [16:0] bound);
        if (bound >= 17'h0FFFF)
            return 16'hFFFF;
        return 16'($urandom_range(int'(bound) + 1, 65535));
    endfunction

    function automatic logic [15:0] frames_for(input logic [15:0] thr);
        if (thr != 16'd0 && $urandom_range(0, 99) < 15)
            return 16'($urandom_range(0, int'(thr) - 1));
        return 16'($urandom_range(int'(thr), 65535));
    endfunction

    function automatic logic [7:0] appl_mostly_active(input int one_in);
        if ($urandom_range(1, one_in) == 1)
            return 8'd0;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [15:0] base,
                              input logic [7:0] appl, input logic [15:0] frames);
        rfid_pkg::t_in_item it;
        it.op = op;
        it.base_level = base;
        it.appl_state = appl;
        it.max_frames = frames;
        pending_ops.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_alarms.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rfid_pkg::CFG_FIXED_OFFSET:    det_cfg.fixed_offset = val;
            rfid_pkg::CFG_OVERLAP_MARGIN:  det_cfg.overlap_margin = val;
            rfid_pkg::CFG_FRAME_THRESHOLD: det_cfg.frame_threshold = val;
            default:                       det_cfg.default_offset = val[7:0];
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] fixed, input logic [15:0] margin,
                              input logic [15:0] thr, input logic [15:0] dflt);
        wait_drained();
        write_reg(rfid_pkg::CFG_FIXED_OFFSET, fixed);
        write_reg(rfid_pkg::CFG_OVERLAP_MARGIN, margin);
        write_reg(rfid_pkg::CFG_FRAME_THRESHOLD, thr);
        write_reg(rfid_pkg::CFG_DEFAULT_OFFSET, dflt);
    endtask

    // Each episode qualifies interference with a long run of active ticks
    // above the threshold, then wanders through the confirm, pause and
    // timeout states.
    task automatic run_phase(input logic [15:0] fixed, input logic [15:0] margin,
                             input logic [15:0] thr, input logic [15:0] dflt,
                             input int episodes, input int noise_len);
        logic [16:0] bound;
        logic [15:0] below_cap;
        logic [7:0]  appl;
        int          active;
        int          goal;
        int          pick;
        set_config(fixed, margin, thr, dflt);
        bound = ((fixed != 16'd0) ? {1'b0, fixed} : {9'd0, dflt[7:0]}) + {1'b0, margin};
        below_cap = (bound > 17'h0FFFF) ? 16'hFFFF : bound[15:0];
        repeat (episodes) begin
            queue_item(rfid_pkg::OP_INIT, 16'($urandom), 8'($urandom), 16'($urandom));
            active = 0;
            goal = int'(rfid_pkg::COUNT_LIMIT) + 1 + int'($urandom_range(0, 8));
            while (active < goal) begin
                appl = appl_mostly_active(16);
                if (appl != 8'd0)
                    active++;
                queue_item(rfid_pkg::OP_TICK, level_above(bound), appl, frames_for(thr));
            end
            repeat (WALK_LEN) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    queue_item(rfid_pkg::OP_TICK, level_above(bound), appl_mostly_active(4),
                               frames_for(thr));
                else if (pick < 80)
                    queue_item(rfid_pkg::OP_TICK, 16'($urandom), 8'($urandom),
                               frames_for(thr));
                else if (pick < 88)
                    queue_item(rfid_pkg::OP_TIME, 16'($urandom), 8'($urandom),
                               16'($urandom));
                else if (pick < 92)
                    queue_item(rfid_pkg::OP_NONE, 16'($urandom), 8'($urandom),
                               16'($urandom));
                else
                    queue_item(rfid_pkg::OP_TICK, 16'($urandom_range(0, int'(below_cap))),
                               8'($urandom), frames_for(thr));
            end
        end
        repeat (noise_len)
            queue_item(2'($urandom_range(rfid_pkg::OP_TICK, rfid_pkg::OP_NONE)),
                       16'($urandom), 8'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Out of reset the offset is zero and never adapts until initialized.
        queue_item(rfid_pkg::OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_item(rfid_pkg::OP_NONE, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_item(rfid_pkg::OP_TIME, 16'h0000, 8'h00, 16'h0000);
        queue_item(rfid_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000);

        // The threshold sum must not wrap at 16 bits.
        set_config(16'hFFFF, 16'h0001, 16'hFFFF, 16'hA5FF);
        queue_item(rfid_pkg::OP_INIT, 16'h0000, 8'h00, 16'h0000);
        queue_item(rfid_pkg::OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_item(rfid_pkg::OP_TICK, 16'h0001, 8'h00, 16'h0000);

        // Dynamic tracking halves toward lower levels.
        set_config(16'h0000, 16'h0010, 16'h0008, 16'h0080);
        queue_item(rfid_pkg::OP_INIT, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_item(rfid_pkg::OP_TICK, 16'h0002, 8'h01, 16'h0000);
        queue_item(rfid_pkg::OP_TICK, 16'h0001, 8'h01, 16'h0000);
        queue_item(rfid_pkg::OP_TICK, 16'h0000, 8'h01, 16'h0000);
        queue_item(rfid_pkg::OP_TICK, 16'hFFFF, 8'h00, 16'h0000);
        queue_item(rfid_pkg::OP_TICK, 16'hFFFF, 8'h01, 16'hFFFF);
        queue_item(rfid_pkg::OP_TICK, 16'h0030, 8'h80, 16'h0000);
        queue_item(rfid_pkg::OP_TIME, 16'h5555, 8'hAA, 16'h5555);
        queue_item(rfid_pkg::OP_TIME, 16'hAAAA, 8'h55, 16'hAAAA);
        queue_item(rfid_pkg::OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_item(rfid_pkg::OP_NONE, 16'h0000, 8'h00, 16'h0000);
        queue_item(rfid_pkg::OP_INIT, 16'h0000, 8'h00, 16'h0000);

        run_phase(16'h0000, 16'h0000, 16'h0000, 16'h00FF, 1, 40);
        run_phase(16'h1234, 16'h0400, 16'h8000, 16'h0042, 1, 40);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 40);
        wait_drained();
        quiet = 1'b1;
        run_phase(16'h0000, 16'h0001, 16'h0100, 16'h0000, 0, 60);

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
